[design/lru_key_value_cache_core_macros.svh]
// Assertion macros for the LRU key-value cache core.
// Depends on nothing; included by the files that carry assertions.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

`ifndef SYNTH
// Condition must hold at every clock edge outside reset.
`define LKVC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LKVC_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[design/lkvc_pkg.sv]
// Shared constants and types for the LRU key-value cache core.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package lkvc_pkg;

   localparam int ENTRIES     = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;

   // Slot index and age rank widths
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   // Entry count holds 0..ENTRIES
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   // Capacity register, fixed at five bits
   localparam int CAP_W  = 5;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Action codes
   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   // Result of the parallel key search
   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [IDX_W-1:0]  victim_idx;
      logic [RANK_W-1:0] victim_rank;
      logic [IDX_W-1:0]  free_idx;
   } lookup_type;

   // One result item
   typedef struct packed {
      logic                   hit;
      logic [VALUE_WIDTH-1:0] read_value;
      logic                   evicted;
   } rsp_type;

endpackage

[design/lkvc_match.sv]
// Parallel key compare, victim search and free slot search over all entries.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_match (
   input  logic [lkvc_pkg::KEY_WIDTH-1:0] keys   [lkvc_pkg::ENTRIES],
   input  logic                           valid  [lkvc_pkg::ENTRIES],
   input  logic [lkvc_pkg::RANK_W-1:0]    ranks  [lkvc_pkg::ENTRIES],
   input  logic [lkvc_pkg::CNT_W-1:0]     count,
   input  logic [lkvc_pkg::KEY_WIDTH-1:0] key,
   output lkvc_pkg::lookup_type           lookup
);

   logic [lkvc_pkg::RANK_W-1:0] oldest_rank;

   // Least recent valid entry carries rank count-1
   assign oldest_rank = lkvc_pkg::RANK_W'(count - lkvc_pkg::CNT_W'(1));

   // Scan from the top so the lowest matching slot wins
   always_comb begin
      lookup             = '0;
      lookup.victim_rank = oldest_rank;
      for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (valid[i] && (keys[i] == key)) begin
            lookup.hit     = 1'b1;
            lookup.hit_idx = lkvc_pkg::IDX_W'(i);
         end
         if (valid[i] && (ranks[i] == oldest_rank)) begin
            lookup.victim_idx = lkvc_pkg::IDX_W'(i);
         end
         if (!valid[i]) begin
            lookup.free_idx = lkvc_pkg::IDX_W'(i);
         end
      end
   end

endmodule

[design/lkvc_store.sv]
// Entry array with keys, values, valid bits, age ranks and fill count,
// plus the access decision and LRU update. Depends on lkvc_pkg, lkvc_match.
`timescale 1ns / 1ps

module lkvc_store (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_vld,
   input  logic                             in_action,
   input  logic [lkvc_pkg::KEY_WIDTH-1:0]   in_key,
   input  logic [lkvc_pkg::VALUE_WIDTH-1:0] in_value,
   input  logic [lkvc_pkg::CAP_W-1:0]       capacity,
   output lkvc_pkg::rsp_type                rsp,
   output logic                             empty
);

   logic [lkvc_pkg::KEY_WIDTH-1:0]   keys_ff   [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::VALUE_WIDTH-1:0] values_ff [lkvc_pkg::ENTRIES];
   logic                             valid_ff  [lkvc_pkg::ENTRIES];
   logic                             valid_in  [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::RANK_W-1:0]      rank_ff   [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::RANK_W-1:0]      rank_in   [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::CNT_W-1:0]       count_ff;
   logic [lkvc_pkg::CNT_W-1:0]       count_in;

   lkvc_pkg::lookup_type        lookup;
   logic [lkvc_pkg::CMP_W-1:0]  cap_sat;
   logic [lkvc_pkg::CMP_W-1:0]  count_ext;
   logic                        wr_key_en;
   logic                        wr_val_en;
   logic [lkvc_pkg::IDX_W-1:0]  wr_idx;
   logic                        prom_en;
   logic                        prom_all;
   logic [lkvc_pkg::IDX_W-1:0]  prom_idx;
   logic [lkvc_pkg::RANK_W-1:0] prom_limit;

   lkvc_match u_match (
      .keys   (keys_ff),
      .valid  (valid_ff),
      .ranks  (rank_ff),
      .count  (count_ff),
      .key    (in_key),
      .lookup (lookup)
   );

   // Clamp capacity to the array depth
   always_comb begin
      cap_sat = lkvc_pkg::CMP_W'(capacity);
      if (cap_sat > lkvc_pkg::CMP_W'(lkvc_pkg::ENTRIES)) begin
         cap_sat = lkvc_pkg::CMP_W'(lkvc_pkg::ENTRIES);
      end
   end

   assign count_ext = lkvc_pkg::CMP_W'(count_ff);
   assign empty     = (count_ff == '0);

   // Decide the access: result, slot write and promotion
   always_comb begin
      rsp        = '0;
      valid_in   = valid_ff;
      count_in   = count_ff;
      wr_key_en  = 1'b0;
      wr_val_en  = 1'b0;
      wr_idx     = lookup.hit_idx;
      prom_en    = 1'b0;
      prom_all   = 1'b0;
      prom_idx   = lookup.hit_idx;
      prom_limit = rank_ff[lookup.hit_idx];
      if (in_vld) begin
         if (lookup.hit) begin
            rsp.hit = 1'b1;
            prom_en = 1'b1;
            if (in_action == lkvc_pkg::ACTION_PUT) begin
               wr_val_en      = 1'b1;
               rsp.read_value = in_value;
            end else begin
               rsp.read_value = values_ff[lookup.hit_idx];
            end
         end else if (in_action == lkvc_pkg::ACTION_GET) begin
            rsp.read_value = '1;
         end else begin
            rsp.read_value = in_value;
            if (cap_sat == '0) begin
               // Pair goes in and straight back out
               rsp.evicted = 1'b1;
            end else if (count_ext >= cap_sat) begin
               // Replace the least recent entry
               rsp.evicted = 1'b1;
               wr_key_en   = 1'b1;
               wr_val_en   = 1'b1;
               wr_idx      = lookup.victim_idx;
               prom_en     = 1'b1;
               prom_idx    = lookup.victim_idx;
               prom_limit  = lookup.victim_rank;
            end else begin
               // Fill the first free slot, everyone else ages
               wr_key_en                 = 1'b1;
               wr_val_en                 = 1'b1;
               wr_idx                    = lookup.free_idx;
               valid_in[lookup.free_idx] = 1'b1;
               count_in                  = count_ff + lkvc_pkg::CNT_W'(1);
               prom_en                   = 1'b1;
               prom_all                  = 1'b1;
               prom_idx                  = lookup.free_idx;
            end
         end
      end
   end

   // Age younger entries and make the touched slot most recent
   always_comb begin
      rank_in = rank_ff;
      if (prom_en) begin
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            if (valid_ff[i] && (lkvc_pkg::IDX_W'(i) != prom_idx) &&
                (prom_all || (rank_ff[i] < prom_limit))) begin
               rank_in[i] = rank_ff[i] + lkvc_pkg::RANK_W'(1);
            end
         end
         rank_in[prom_idx] = '0;
      end
   end

   // Control state: valid bits, ranks, count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         count_ff <= count_in;
      end
   end

   // Payload: keys and values
   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         keys_ff[wr_idx] <= in_key;
      end
      if (wr_val_en) begin
         values_ff[wr_idx] <= in_value;
      end
   end

endmodule

[design/lru_key_value_cache_core.sv]
// Top level of the LRU key-value cache: request and response registers,
// capacity register and assertions. Depends on lkvc_pkg, lkvc_store, macros.
`timescale 1ns / 1ps
`include "lru_key_value_cache_core_macros.svh"

// Fully associative 16-entry key-value cache with least-recently-used
// replacement.
// Requests: a get (req_action 0) or put (req_action 1) with req_key and
// req_value is transferred at a clock edge where start is high and busy low.
// busy is high only in the cycle after reset, so a request can be taken in
// every cycle.
// Responses: rsp_hit, rsp_read_value and rsp_evicted are valid for one cycle
// while rsp_strobe is high; the request passes the request register and then
// the response register before the strobe rises. The receiver cannot stall,
// so one response leaves per cycle.
// The request register feeds one pass of key compare, victim and free-slot
// search and rank update, which writes the entry array and the response
// register at the same edge; the next request sees the updated ranks.
// Configuration: csr_data is the capacity (reset 16, above 16 acts as 16);
// csr_ready is always high and a write is dropped unless the cache is empty.
// Reset clears valid bits, ranks and the count at once; no clearing pass.

module lru_key_value_cache_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_action,
   input  logic signed [lkvc_pkg::KEY_WIDTH-1:0]   req_key,
   input  logic signed [lkvc_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                    rsp_strobe,
   output logic                                    rsp_hit,
   output logic signed [lkvc_pkg::VALUE_WIDTH-1:0] rsp_read_value,
   output logic                                    rsp_evicted,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]              csr_data
);

   logic                             busy_ff;
   logic                             in_vld_ff;
   logic                             in_vld_in;
   logic                             in_action_ff;
   logic [lkvc_pkg::KEY_WIDTH-1:0]   in_key_ff;
   logic [lkvc_pkg::VALUE_WIDTH-1:0] in_value_ff;
   logic [lkvc_pkg::CAP_W-1:0]       capacity_ff;
   logic                             cap_wr;
   logic                             store_empty;
   lkvc_pkg::rsp_type                rsp_in;
   lkvc_pkg::rsp_type                rsp_ff;
   logic                             rsp_strobe_ff;

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign in_vld_in = start && !busy_ff;
   assign cap_wr    = csr_valid && csr_ready && store_empty;

   // Hold busy through reset and clear it once reset is released
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // Capture a request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld_in) begin
         in_action_ff <= req_action;
         in_key_ff    <= req_key;
         in_value_ff  <= req_value;
      end
   end

   // Capacity register, written only while empty
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAP_RESET;
      end else if (cap_wr) begin
         capacity_ff <= csr_data;
      end
   end

   lkvc_store u_store (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (in_vld_ff),
      .in_action (in_action_ff),
      .in_key    (in_key_ff),
      .in_value  (in_value_ff),
      .capacity  (capacity_ff),
      .rsp       (rsp_in),
      .empty     (store_empty)
   );

   // Register the response and its strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hit        = rsp_ff.hit;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_evicted    = rsp_ff.evicted;

   // Every captured request yields a response next cycle
   `LKVC_ASSERT_NEXT(a_rsp_follows, clock, reset, in_vld_ff, rsp_strobe_ff, "missing response")
   // A response without a captured request is invented
   `LKVC_ASSERT_NEXT(a_no_extra_rsp, clock, reset, !in_vld_ff, !rsp_strobe_ff, "extra response")
   // Eviction only happens on a miss
   `LKVC_ASSERT_ALWAYS(a_evict_miss, clock, reset,
                       !(rsp_strobe_ff && rsp_ff.evicted && rsp_ff.hit), "evict on hit")
   // Capacity holds when a write arrives while entries are present
   `LKVC_ASSERT_NEXT(a_cap_hold, clock, reset, csr_valid && !store_empty,
                     $stable(capacity_ff), "capacity changed while not empty")

endmodule
